@@ hw/rtl/block_average_pixelizer_macros.svh @@
// assertion macros used by the rtl controller
`ifndef BLOCK_AVERAGE_PIXELIZER_MACROS_SVH
`define BLOCK_AVERAGE_PIXELIZER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BPX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bpx_pkg.sv @@
package bpx_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_BLOCK  = 16;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int TILE_W     = 8;
    localparam int SUM_W      = 16;
    localparam int CFG_DIM_W  = 9;
    localparam int CFG_BLK_W  = 5;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CHAN_N     = 3;

    // register values after reset
    localparam logic [CFG_DIM_W-1:0] RST_WIDTH  = CFG_DIM_W'(256);
    localparam logic [CFG_DIM_W-1:0] RST_HEIGHT = CFG_DIM_W'(256);
    localparam logic [CFG_BLK_W-1:0] RST_BLOCK  = CFG_BLK_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_BLOCK  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic acc;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic complete;
        logic div_done;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_rgb_sum;

endpackage

@@ hw/rtl/bpx_div.sv @@
module bpx_div
    import bpx_pkg::*;
#(
    parameter int CNT_W = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [CHAN_N-1:0][SUM_W-1:0]        i_dividend,
    input  logic [CNT_W-1:0]                    i_divisor,
    output logic                                o_done,
    output logic [CHAN_N-1:0][PIX_W-1:0]        o_quot
);

    localparam int STEP_W = $clog2(SUM_W);

    logic                          r_busy;
    logic                          r_done;
    logic [STEP_W-1:0]             r_step;
    logic [CNT_W-1:0]              r_div;
    logic [CHAN_N-1:0][CNT_W-1:0]  r_rem;
    logic [CHAN_N-1:0][SUM_W-1:0]  r_quo;
    logic [CHAN_N-1:0][CNT_W-1:0]  n_rem;
    logic [CHAN_N-1:0][SUM_W-1:0]  n_quo;
    logic [CNT_W:0]                shifted;

    // one restoring step per lane
    always_comb begin
        shifted = '0;
        for (int c = 0; c < CHAN_N; c++) begin
            shifted = {r_rem[c], r_quo[c][SUM_W-1]};
            if (shifted >= {1'b0, r_div}) begin
                n_rem[c] = CNT_W'(shifted - {1'b0, r_div});
                n_quo[c] = {r_quo[c][SUM_W-2:0], 1'b1};
            end else begin
                n_rem[c] = shifted[CNT_W-1:0];
                n_quo[c] = {r_quo[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // saturate means above the pixel range
    always_comb begin
        for (int c = 0; c < CHAN_N; c++) begin
            o_quot[c] = (|r_quo[c][SUM_W-1:PIX_W]) ? '1 : r_quo[c][PIX_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

@@ hw/rtl/bpx_dp.sv @@
module bpx_dp
    import bpx_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = DEF_MAX_BLOCK
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [PIX_W-1:0]      i_red,
    input  logic [PIX_W-1:0]      i_green,
    input  logic [PIX_W-1:0]      i_blue,
    input  logic                  i_frame_start,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [TILE_W-1:0]     o_tile_row,
    output logic [TILE_W-1:0]     o_tile_column,
    output logic [PIX_W-1:0]      o_avg_red,
    output logic [PIX_W-1:0]      o_avg_green,
    output logic [PIX_W-1:0]      o_avg_blue,
    output logic                  o_frame_done
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int BW    = $clog2(MAX_BLOCK);
    localparam int CNT_W = 2 * (BW + 1);

    logic [CFG_DIM_W-1:0] r_cfg_width;
    logic [CFG_DIM_W-1:0] r_cfg_height;
    logic [CFG_BLK_W-1:0] r_cfg_block;

    logic [CW-1:0] r_pix_col;
    logic [RW-1:0] r_pix_row;
    logic [BW-1:0] r_cit;
    logic [BW-1:0] r_rit;
    logic [CW-1:0] r_tile_col;
    logic [RW-1:0] r_tile_row;

    logic [PIX_W-1:0] r_red;
    logic [PIX_W-1:0] r_green;
    logic [PIX_W-1:0] r_blue;

    t_rgb_sum             r_sum_mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] r_vld;
    t_rgb_sum             r_rd_data;
    logic                 r_rd_vld;

    logic [TILE_W-1:0] r_res_row;
    logic [TILE_W-1:0] r_res_col;
    logic              r_res_done;

    logic              r_o_valid;
    logic [TILE_W-1:0] r_o_tile_row;
    logic [TILE_W-1:0] r_o_tile_col;
    logic [PIX_W-1:0]  r_o_red;
    logic [PIX_W-1:0]  r_o_green;
    logic [PIX_W-1:0]  r_o_blue;
    logic              r_o_done;

    logic [CW-1:0]  w_last;
    logic [RW-1:0]  h_last;
    logic [BW-1:0]  b_last;
    logic [CW-1:0]  rd_addr;
    t_rgb_sum       sum_new;
    logic           row_end;
    logic           col_end;
    logic           complete;
    logic [BW:0]    cit_n;
    logic [BW:0]    rit_n;
    logic [CNT_W-1:0] count;
    logic [CHAN_N-1:0][SUM_W-1:0] div_in;
    logic [CHAN_N-1:0][PIX_W-1:0] div_q;
    logic           div_done;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_block  <= RST_BLOCK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_HEIGHT: r_cfg_height <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_BLOCK:  r_cfg_block  <= i_cfg_data[CFG_BLK_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped limits, kept as last index
    always_comb begin
        if (r_cfg_width == '0) begin
            w_last = '0;
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_cfg_width - 1'b1);
        end
        if (r_cfg_height == '0) begin
            h_last = '0;
        end else if (32'(r_cfg_height) > 32'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(r_cfg_height - 1'b1);
        end
        if (r_cfg_block == '0) begin
            b_last = '0;
        end else if (32'(r_cfg_block) > 32'(MAX_BLOCK)) begin
            b_last = BW'(MAX_BLOCK - 1);
        end else begin
            b_last = BW'(r_cfg_block - 1'b1);
        end
    end

    assign rd_addr = i_frame_start ? '0 : r_tile_col;

    always_comb begin
        sum_new.red   = (r_rd_vld ? r_rd_data.red   : '0) + SUM_W'(r_red);
        sum_new.green = (r_rd_vld ? r_rd_data.green : '0) + SUM_W'(r_green);
        sum_new.blue  = (r_rd_vld ? r_rd_data.blue  : '0) + SUM_W'(r_blue);
    end

    assign row_end  = r_pix_col >= w_last;
    assign col_end  = r_pix_row >= h_last;
    assign complete = (row_end || r_cit >= b_last) && (col_end || r_rit >= b_last);
    assign cit_n    = (BW+1)'(r_cit) + 1'b1;
    assign rit_n    = (BW+1)'(r_rit) + 1'b1;
    assign count    = CNT_W'(cit_n) * CNT_W'(rit_n);
    assign div_in   = {sum_new.red, sum_new.green, sum_new.blue};

    // column sum memory, one entry per block column
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_data <= r_sum_mem[rd_addr];
        end
        if (i_cmd.acc && !complete) begin
            r_sum_mem[r_tile_col] <= sum_new;
        end
    end

    // an entry that is not valid reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.accept) begin
            r_rd_vld <= i_frame_start ? 1'b0 : r_vld[rd_addr];
            if (i_frame_start) begin
                r_vld <= '0;
            end
        end else if (i_cmd.acc) begin
            r_vld[r_tile_col] <= !complete;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_col  <= '0;
            r_pix_row  <= '0;
            r_cit      <= '0;
            r_rit      <= '0;
            r_tile_col <= '0;
            r_tile_row <= '0;
        end else if (i_cmd.accept && i_frame_start) begin
            r_pix_col  <= '0;
            r_pix_row  <= '0;
            r_cit      <= '0;
            r_rit      <= '0;
            r_tile_col <= '0;
            r_tile_row <= '0;
        end else if (i_cmd.acc) begin
            if (row_end) begin
                r_pix_col  <= '0;
                r_cit      <= '0;
                r_tile_col <= '0;
                if (col_end) begin
                    r_pix_row  <= '0;
                    r_rit      <= '0;
                    r_tile_row <= '0;
                end else begin
                    r_pix_row <= r_pix_row + 1'b1;
                    if (r_rit >= b_last) begin
                        r_rit      <= '0;
                        r_tile_row <= r_tile_row + 1'b1;
                    end else begin
                        r_rit <= r_rit + 1'b1;
                    end
                end
            end else begin
                r_pix_col <= r_pix_col + 1'b1;
                if (r_cit >= b_last) begin
                    r_cit      <= '0;
                    r_tile_col <= r_tile_col + 1'b1;
                end else begin
                    r_cit <= r_cit + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && complete) begin
            r_res_row  <= TILE_W'(r_tile_row);
            r_res_col  <= TILE_W'(r_tile_col);
            r_res_done <= row_end && col_end;
        end
    end

    bpx_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.acc && complete),
        .i_dividend (div_in),
        .i_divisor  (count),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_tile_row <= r_res_row;
            r_o_tile_col <= r_res_col;
            r_o_red      <= div_q[2];
            r_o_green    <= div_q[1];
            r_o_blue     <= div_q[0];
            r_o_done     <= r_res_done;
        end
    end

    assign o_sts.complete = complete;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_o_valid || !i_stall;

    assign o_valid       = r_o_valid;
    assign o_tile_row    = r_o_tile_row;
    assign o_tile_column = r_o_tile_col;
    assign o_avg_red     = r_o_red;
    assign o_avg_green   = r_o_green;
    assign o_avg_blue    = r_o_blue;
    assign o_frame_done  = r_o_done;

endmodule

@@ hw/rtl/bpx_ctrl.sv @@
`include "block_average_pixelizer_macros.svh"

module bpx_ctrl
    import bpx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = 1'b0;
        o_cmd.acc      = 1'b0;
        o_cmd.out_load = 1'b0;
        o_stall        = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.complete ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `BPX_ASSERT_NEXT(a_accept_to_acc, o_cmd.accept, r_state == S_ACC, "accepted item not summed")
    `BPX_ASSERT_NOW(a_div_done_in_div, i_sts.div_done, r_state == S_DIV, "divider done out of turn")
    `BPX_ASSERT_NEXT(a_load_to_idle, o_cmd.out_load, r_state == S_IDLE && !o_stall, "no return to idle")

endmodule

@@ hw/rtl/block_average_pixelizer.sv @@
// a pixel that finishes no block is accepted, then its column sum is updated;
// a pixel that finishes a block then goes through the divider and waits for an
// output slot; a new pixel is taken only once the last one is through, at a rate
// set by the column sum memory read/write turn, the bit-serial divider and i_stall
// reset: synchronous active low; registers back to width 256, height 256, block 8,
// raster position at the origin, all column sums reading as zero at once
module block_average_pixelizer
    import bpx_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_BLOCK  = DEF_MAX_BLOCK
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel item in
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_red,
    input  logic [PIX_W-1:0]      i_green,
    input  logic [PIX_W-1:0]      i_blue,
    input  logic                  i_frame_start,
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // block item out
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [TILE_W-1:0]     o_tile_row,
    output logic [TILE_W-1:0]     o_tile_column,
    output logic [PIX_W-1:0]      o_avg_red,
    output logic [PIX_W-1:0]      o_avg_green,
    output logic [PIX_W-1:0]      o_avg_blue,
    output logic                  o_frame_done
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: idle -> sum update -> (divide -> wait for output slot) -> idle
    bpx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: position counters, per block column sums, divider, output register
    // the output register lets the next pixel in while a block result waits
    bpx_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BLOCK  (MAX_BLOCK)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_frame_start (i_frame_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_tile_row    (o_tile_row),
        .o_tile_column (o_tile_column),
        .o_avg_red     (o_avg_red),
        .o_avg_green   (o_avg_green),
        .o_avg_blue    (o_avg_blue),
        .o_frame_done  (o_frame_done)
    );

endmodule

@@ verif/tb_block_average_pixelizer.sv @@
`timescale 1ns / 1ps

module tb_block_average_pixelizer;
    import bpx_pkg::*;

    // effective limits, matching the block's default parameters
    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;
    localparam int MAX_B = DEF_MAX_BLOCK;

    // settle time after the last result before touching registers
    localparam int SETTLE_CYCLES = 25;

    // pixel item as queued for the driver
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_start;
    } t_pixel;

    // one finished block as it should leave the block
    typedef struct packed {
        logic [TILE_W-1:0] tile_row;
        logic [TILE_W-1:0] tile_column;
        logic [PIX_W-1:0]  avg_red;
        logic [PIX_W-1:0]  avg_green;
        logic [PIX_W-1:0]  avg_blue;
        logic              frame_done;
    } t_block;

    // dut ports, all inputs known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_red         = '0;
    logic [PIX_W-1:0]      i_green       = '0;
    logic [PIX_W-1:0]      i_blue        = '0;
    logic                  i_frame_start = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic [TILE_W-1:0]     o_tile_row;
    logic [TILE_W-1:0]     o_tile_column;
    logic [PIX_W-1:0]      o_avg_red;
    logic [PIX_W-1:0]      o_avg_green;
    logic [PIX_W-1:0]      o_avg_blue;
    logic                  o_frame_done;

    // stimulus and expectations
    t_pixel pending_pixels[$];
    t_block expected_blocks[$];
    t_pixel next_pixel;
    t_block oldest_block;
    int     mismatch_count = 0;

    // sender burst shaping and receiver stall pattern
    int burst_left = 1;
    int gap_left   = 0;
    int stall_left = 0;
    int free_left  = 0;

    // predictor copy of registers and raster state
    logic [CFG_DIM_W-1:0] cfg_width;
    logic [CFG_DIM_W-1:0] cfg_height;
    logic [CFG_BLK_W-1:0] cfg_block;
    logic [7:0]           pos_col;
    logic [7:0]           pos_row;
    logic [3:0]           col_in_tile;
    logic [3:0]           row_in_tile;
    logic [TILE_W-1:0]    tile_col;
    logic [TILE_W-1:0]    tile_row;
    t_rgb_sum             column_sums [MAX_W];

    block_average_pixelizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_frame_start (i_frame_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tile_row    (o_tile_row),
        .o_tile_column (o_tile_column),
        .o_avg_red     (o_avg_red),
        .o_avg_green   (o_avg_green),
        .o_avg_blue    (o_avg_blue),
        .o_frame_done  (o_frame_done)
    );

    always #5 i_clk = ~i_clk;

    // zero or too large register values fall back to the nearest legal one
    function automatic int eff_reg(input int value, input int hi);
        if (value == 0) return 1;
        if (value > hi) return hi;
        return value;
    endfunction

    // truncated mean, saturating when stale sums overshoot
    function automatic logic [PIX_W-1:0] channel_mean(input logic [SUM_W-1:0] acc,
                                                      input int count);
        int q;
        q = int'(acc) / count;
        return (q > 255) ? 8'd255 : q[PIX_W-1:0];
    endfunction

    // back to the origin with every column sum cleared
    function automatic void restart_frame();
        pos_col     = '0;
        pos_row     = '0;
        col_in_tile = '0;
        row_in_tile = '0;
        tile_col    = '0;
        tile_row    = '0;
        foreach (column_sums[k]) column_sums[k] = '0;
    endfunction

    // predictor: fold one accepted pixel in, queue the block it finishes
    function automatic void track_pixel(input t_pixel px);
        int     w, h, bs, count;
        bit     row_end, col_end, tile_col_end, tile_row_end;
        t_block done_block;
        if (px.frame_start) restart_frame();
        w  = eff_reg(int'(cfg_width), MAX_W);
        h  = eff_reg(int'(cfg_height), MAX_H);
        bs = eff_reg(int'(cfg_block), MAX_B);

        // sums are 16 bits and wrap
        column_sums[tile_col].red   = column_sums[tile_col].red + px.red;
        column_sums[tile_col].green = column_sums[tile_col].green + px.green;
        column_sums[tile_col].blue  = column_sums[tile_col].blue + px.blue;

        // counters at or past a limit end their row or block
        row_end      = int'(pos_col) >= w - 1;
        col_end      = int'(pos_row) >= h - 1;
        tile_col_end = row_end || int'(col_in_tile) >= bs - 1;
        tile_row_end = col_end || int'(row_in_tile) >= bs - 1;

        if (tile_col_end && tile_row_end) begin
            // clipped edge blocks divide by their real pixel count
            count = (int'(col_in_tile) + 1) * (int'(row_in_tile) + 1);
            done_block.tile_row    = tile_row;
            done_block.tile_column = tile_col;
            done_block.avg_red     = channel_mean(column_sums[tile_col].red, count);
            done_block.avg_green   = channel_mean(column_sums[tile_col].green, count);
            done_block.avg_blue    = channel_mean(column_sums[tile_col].blue, count);
            done_block.frame_done  = row_end && col_end;
            expected_blocks.push_back(done_block);
            column_sums[tile_col] = '0;
        end

        // raster advance, wrapping to the origin after the last pixel
        if (row_end) begin
            pos_col     = '0;
            col_in_tile = '0;
            tile_col    = '0;
            if (col_end) begin
                pos_row     = '0;
                row_in_tile = '0;
                tile_row    = '0;
            end else begin
                pos_row = pos_row + 1'b1;
                if (int'(row_in_tile) >= bs - 1) begin
                    row_in_tile = '0;
                    tile_row    = tile_row + 1'b1;
                end else begin
                    row_in_tile = row_in_tile + 1'b1;
                end
            end
        end else begin
            pos_col = pos_col + 1'b1;
            if (int'(col_in_tile) >= bs - 1) begin
                col_in_tile = '0;
                tile_col    = tile_col + 1'b1;
            end else begin
                col_in_tile = col_in_tile + 1'b1;
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", field, got, want));
    endtask

    // driver: bursts of items with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                next_pixel = pending_pixels.pop_front();
                i_red         <= next_pixel.red;
                i_green       <= next_pixel.green;
                i_blue        <= next_pixel.blue;
                i_frame_start <= next_pixel.frame_start;
                i_valid       <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: stall runs, short and long, between free stretches
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (free_left > 0) begin
            i_stall <= 1'b0;
            free_left--;
        end else begin
            i_stall    <= 1'b0;
            free_left  = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 15);
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 25)
                                                     : $urandom_range(1, 4);
        end
    end

    // monitor: register writes and accepted pixels feed the predictor,
    // accepted blocks are checked against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  = RST_WIDTH;
            cfg_height = RST_HEIGHT;
            cfg_block  = RST_BLOCK;
            restart_frame();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:  cfg_width  = i_cfg_data;
                    CFG_HEIGHT: cfg_height = i_cfg_data;
                    CFG_BLOCK:  cfg_block  = i_cfg_data[CFG_BLK_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                track_pixel('{red: i_red, green: i_green, blue: i_blue,
                              frame_start: i_frame_start});
            if (o_valid && !i_stall) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch($sformatf("block (%0d,%0d) with none expected",
                                              o_tile_row, o_tile_column));
                end else begin
                    oldest_block = expected_blocks.pop_front();
                    check_field("tile_row", int'(o_tile_row),
                                int'(oldest_block.tile_row));
                    check_field("tile_column", int'(o_tile_column),
                                int'(oldest_block.tile_column));
                    check_field("avg_red", int'(o_avg_red), int'(oldest_block.avg_red));
                    check_field("avg_green", int'(o_avg_green),
                                int'(oldest_block.avg_green));
                    check_field("avg_blue", int'(o_avg_blue), int'(oldest_block.avg_blue));
                    check_field("frame_done", int'(o_frame_done),
                                int'(oldest_block.frame_done));
                end
            end
        end
    end

    function automatic void queue_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                        input logic [PIX_W-1:0] b, input logic fs);
        pending_pixels.push_back('{red: r, green: g, blue: b, frame_start: fs});
    endfunction

    // channel values lean toward the extremes
    function automatic logic [PIX_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // raster run of random colors; noisy runs scatter stray frame starts
    function automatic void queue_run(input int count, input bit first_start, input bit noisy);
        for (int i = 0; i < count; i++)
            queue_pixel(pick_channel(), pick_channel(), pick_channel(),
                        (i == 0 && first_start) || (noisy && $urandom_range(0, 7) == 0));
    endfunction

    // width or height register value, sometimes zero or past the maximum
    function automatic int pick_dim(input int span);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(MAX_W + 1, 511);
            default: return $urandom_range(1, span);
        endcase
    endfunction

    // nothing queued, nothing in flight, then let the last pixel settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_valid || expected_blocks.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register writes only while the block is idle
    task automatic set_format(input int w, input int h, input int b);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(w);
        @(posedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data  <= CFG_DATA_W'(h);
        @(posedge i_clk);
        i_cfg_index <= CFG_BLOCK;
        i_cfg_data  <= CFG_DATA_W'(b);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int w_reg, h_reg, b_reg, frame_pixels, run_len, random_pixels, waited;
        random_pixels = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x2 frame of 2x2 blocks: clipped right column, then a wrap
        // into a second frame without frame_start
        set_format(3, 2, 2);
        for (int i = 0; i < 6; i++) queue_pixel(8'hFF, 8'hFF, 8'hFF, i == 0);
        for (int i = 0; i < 6; i++) queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);

        // zero registers act as 1: every pixel is a whole frame
        set_format(0, 0, 0);
        queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
        queue_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        queue_pixel(8'h01, 8'h02, 8'h03, 1'b1);

        // oversized block acts as 16; frame start mid-frame, then left
        // half done so the next format lands mid-frame
        set_format(4, 3, 31);
        for (int i = 0; i < 3; i++) queue_pixel(8'hFF, 8'hFF, 8'hFF, i == 0);
        for (int i = 0; i < 5; i++) queue_pixel(8'hFF, 8'hFF, 8'hFF, i == 0);

        // full-width row of single-pixel blocks, carrying on from the old
        // position: stale sums saturate the first mean
        set_format(MAX_W, 1, 1);
        queue_run(MAX_W, 1'b0, 1'b0);
        random_pixels += MAX_W;

        // one-pixel-wide column past the height limit, left unfinished
        set_format(1, 511, 0);
        queue_run(140, 1'b1, 1'b0);
        random_pixels += 140;

        // small formats: mostly whole frames, some cut short or noisy
        while (random_pixels < 600) begin
            w_reg = pick_dim(12);
            h_reg = pick_dim(8);
            case ($urandom_range(0, 7))
                0:       b_reg = 0;
                1:       b_reg = $urandom_range(MAX_B + 1, 31);
                2:       b_reg = MAX_B;
                default: b_reg = $urandom_range(1, 5);
            endcase
            set_format(w_reg, h_reg, b_reg);
            frame_pixels = eff_reg(w_reg, MAX_W) * eff_reg(h_reg, MAX_H);
            if (frame_pixels > 80) frame_pixels = 80;
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: begin
                        run_len = frame_pixels;
                        queue_run(run_len, 1'b1, 1'b0);
                    end
                    7: begin
                        // relies on the wrap or continues an old frame
                        run_len = frame_pixels;
                        queue_run(run_len, 1'b0, 1'b0);
                    end
                    8: begin
                        run_len = $urandom_range(1, frame_pixels);
                        queue_run(run_len, 1'b1, 1'b0);
                    end
                    default: begin
                        run_len = $urandom_range(1, 20);
                        queue_run(run_len, 1'b0, 1'b1);
                    end
                endcase
                random_pixels += run_len;
            end
        end

        // drain: all pixels in, every block out, then a quiet tail
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_valid);
        waited = 0;
        while (expected_blocks.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_blocks.size() != 0)
            report_mismatch($sformatf("%0d expected blocks never arrived",
                                      expected_blocks.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
